// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PSIZE_W   = 24;
  localparam int unsigned BSIZE_W   = 16;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Bitmap row geometry
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned WORD_IDX_W = $clog2(WORD_W);

  // Divider: byte offset in the pool over block size
  localparam int unsigned DVD_W = PSIZE_W;
  localparam int unsigned DVR_W = BSIZE_W;

  localparam int unsigned BBA_MAX_BLOCKS = 256;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Response status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_OWNED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ALREADY   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT,   // bitmap clearing sweep after reset
    ST_IDLE,
    ST_SCAN,   // allocate: row-by-row search for a free bit
    ST_MUL,    // allocate: index times block size
    ST_DIV,    // free: offset over block size
    ST_FCHK,   // free: read-modify-write of the addressed row
    ST_CLR,    // clear request sweep
    ST_RESP    // hand word to output register
  } bba_state_e;

endpackage

`default_nettype wire

// ===== src/bba_map_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Used-bit store: one write port, one read port, registered read data.
module bba_map_mem
  import bba_pkg::*;
#(
  parameter int unsigned AW = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/bba_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bba_div
  import bba_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVR_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  dq_q, dq_d;
  logic [DVR_W-1:0]  rem_q, rem_d;
  logic [DVR_W-1:0]  dvr_q, dvr_d;
  logic [DVR_W:0]    shifted;
  logic [DVR_W-1:0]  diff;
  logic              ge;

  assign shifted = {rem_q, dq_q[DVD_W-1]};
  assign diff    = DVR_W'(shifted - {1'b0, dvr_q});
  assign ge      = shifted >= {1'b0, dvr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvr_d  = dvr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvr_d  = divisor_i;
    end else if (busy_q) begin
      dq_d   = {dq_q[DVD_W-2:0], ge};
      rem_d  = ge ? diff : shifted[DVR_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvr_q <= dvr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

// ===== src/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size block pool manager. One used bit per block lives in a bitmap
// memory of 16-bit rows; a single read-modify-write sequencer serves one
// request at a time. Allocate scans rows from row 0, one row per cycle with
// the read of the next row overlapped, and returns pool_base plus the lowest
// free index times the block size. Free checks ownership, runs a bit-serial
// division of the pool offset by the block size, then reads and rewrites one
// row. Clear sweeps every row, one per cycle. After reset the same sweep runs
// before the first request is taken; configuration writes are accepted
// throughout. A finished response word waits in the output register, so the
// next request is taken while it is still pending.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = BBA_MAX_BLOCKS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ADDR_W-1:0]    cfg_wdata_i,
  // request
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [REQ_W-1:0]     req_type_i,
  input  wire logic [ADDR_W-1:0]    addr_i,
  // response
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [STAT_W-1:0]    status_o,
  output logic      [ADDR_W-1:0]    block_addr_o,
  output logic      [CNT_W-1:0]     free_count_o
);

  localparam int unsigned NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BIT_AW    = AW + WORD_IDX_W;
  localparam int unsigned N_W       = ($clog2(MAX_BLOCKS + 1) > CNT_W) ?
                                      $clog2(MAX_BLOCKS + 1) : CNT_W;
  localparam int unsigned PROD_W    = BIT_AW + BSIZE_W;
  localparam logic [AW-1:0]  LAST_ROW = AW'(NUM_WORDS - 1);
  localparam logic [N_W-1:0] N_MAX    = N_W'(MAX_BLOCKS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  pool_base_q;
  logic [PSIZE_W-1:0] pool_size_q;
  logic [BSIZE_W-1:0] blk_bytes_q;
  logic [CNT_W-1:0]   block_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= '0;
      pool_size_q   <= '0;
      blk_bytes_q   <= BSIZE_W'(64);
      block_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POOL_BASE:   pool_base_q   <= cfg_wdata_i;
        CFG_POOL_SIZE:   pool_size_q   <= cfg_wdata_i[PSIZE_W-1:0];
        CFG_BLOCK_SIZE:  blk_bytes_q   <= cfg_wdata_i[BSIZE_W-1:0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_wdata_i[CNT_W-1:0];
      endcase
    end
  end

  // usable block count, capped at the bitmap size
  logic [N_W-1:0] bc_ext;
  logic [N_W-1:0] n_blk;
  logic [N_W-1:0] n_m1;
  logic [AW-1:0]  scan_last;

  assign bc_ext    = N_W'(block_count_q);
  assign n_blk     = (bc_ext < N_MAX) ? bc_ext : N_MAX;
  assign n_m1      = n_blk - 1'b1;
  assign scan_last = AW'(n_m1 >> WORD_IDX_W);

  // ---------------------------------------------------------------------------
  // Ownership check for free, evaluated on the request port
  // ---------------------------------------------------------------------------
  logic [ADDR_W:0]    pool_limit;
  logic [DVD_W-1:0]   offset;
  logic               owned_pre;

  assign pool_limit = {1'b0, pool_base_q} + {{(ADDR_W + 1 - PSIZE_W){1'b0}}, pool_size_q};
  // an owned address lies below base plus a 24-bit size, so the offset fits
  assign offset     = DVD_W'(addr_i - pool_base_q);
  assign owned_pre  = (pool_base_q != '0) && (addr_i != '0) && (addr_i >= pool_base_q) &&
                      ({1'b0, addr_i} < pool_limit) && (blk_bytes_q != '0);

  // ---------------------------------------------------------------------------
  // Bitmap memory and divider
  // ---------------------------------------------------------------------------
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  bba_map_mem #(
    .AW (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;

  bba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (offset),
    .divisor_i  (blk_bytes_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  bba_state_e       state_q, state_d;
  logic [CNT_W-1:0] fc_q, fc_d;
  logic [AW-1:0]    row_q, row_d;        // scan row / clear sweep row
  logic             hit_q, hit_d;        // allocate succeeded
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [BIT_AW-1:0] idx_q, idx_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [ADDR_W-1:0] block_addr_q, block_addr_d;
  logic [CNT_W-1:0]  free_count_q, free_count_d;

  logic              in_accept;
  logic              out_load;

  // free bits of the row under scan, restricted to usable indexes
  logic [WORD_W-1:0]     scan_free;
  logic [WORD_IDX_W-1:0] scan_pos;
  logic [BIT_AW-1:0]     quot_idx;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      scan_free[b] = !mem_rdata[b] &&
                     (N_W'({row_q, WORD_IDX_W'(b)}) < n_blk);
    end
    scan_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (scan_free[b]) begin
        scan_pos = WORD_IDX_W'(b);
      end
    end
  end

  assign quot_idx  = div_quot[BIT_AW-1:0];
  assign in_accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    fc_d         = fc_q;
    row_d        = row_q;
    hit_d        = hit_q;
    res_status_d = res_status_q;
    idx_d        = idx_q;
    prod_d       = prod_q;
    mem_we       = 1'b0;
    mem_waddr    = row_q;
    mem_wdata    = '0;
    mem_raddr    = '0;
    div_start    = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_INIT, ST_CLR: begin
        mem_we = 1'b1;
        row_d  = row_q + 1'b1;
        if (row_q == LAST_ROW) begin
          if (state_q == ST_CLR) begin
            fc_d    = CNT_W'(n_blk);
            state_d = ST_RESP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_IDLE: begin
        // row 0 is read here so a scan starts with data in hand
        mem_raddr = '0;
        if (in_accept) begin
          hit_d        = 1'b0;
          res_status_d = STAT_OK;
          row_d        = '0;
          unique case (req_type_i)
            REQ_ALLOC: begin
              if (fc_q == '0 || n_blk == '0) begin
                res_status_d = STAT_NO_FREE;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            REQ_FREE: begin
              if (owned_pre) begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end else begin
                res_status_d = STAT_NOT_OWNED;
                state_d      = ST_RESP;
              end
            end
            REQ_CLEAR: state_d = ST_CLR;
            default:   state_d = ST_RESP;   // unused code: report only
          endcase
        end
      end

      ST_SCAN: begin
        mem_raddr = row_q + 1'b1;
        if (scan_free != '0) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | (WORD_W'(1) << scan_pos);
          idx_d     = {row_q, scan_pos};
          fc_d      = fc_q - 1'b1;
          hit_d     = 1'b1;
          state_d   = ST_MUL;
        end else if (row_q == scan_last) begin
          res_status_d = STAT_NO_FREE;
          state_d      = ST_RESP;
        end else begin
          row_d = row_q + 1'b1;
        end
      end

      ST_MUL: begin
        prod_d  = PROD_W'(idx_q) * PROD_W'(blk_bytes_q);
        state_d = ST_RESP;
      end

      ST_DIV: begin
        mem_raddr = AW'(div_quot >> WORD_IDX_W);
        if (div_done) begin
          idx_d = quot_idx;
          if (div_quot >= DVD_W'(n_blk)) begin
            res_status_d = STAT_NOT_OWNED;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_FCHK;
          end
        end
      end

      ST_FCHK: begin
        mem_waddr = idx_q[BIT_AW-1:WORD_IDX_W];
        if (!mem_rdata[idx_q[WORD_IDX_W-1:0]]) begin
          res_status_d = STAT_ALREADY;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(WORD_W'(1) << idx_q[WORD_IDX_W-1:0]);
          fc_d      = (fc_q == CNT_MAX) ? fc_q : fc_q + 1'b1;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    block_addr_d = block_addr_q;
    free_count_d = free_count_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      status_d     = res_status_q;
      block_addr_d = hit_q ? (pool_base_q + ADDR_W'(prod_q)) : '0;
      free_count_d = fc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      fc_q        <= '0;
      row_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      row_q       <= row_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    status_q     <= status_d;
    block_addr_q <= block_addr_d;
    free_count_q <= free_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign block_addr_o = block_addr_q;
  assign free_count_o = free_count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_mem_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_INIT || state_q == ST_CLR ||
                state_q == ST_SCAN || state_q == ST_FCHK))
    else $error("bitmap written outside a modify state");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_free != '0) |=> fc_q == $past(fc_q) - 1'b1)
    else $error("free count not lowered on allocation");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the free sequence");

endmodule

`default_nettype wire

// ===== verif/tb_bitmap_block_allocator.sv =====
`timescale 1ns / 1ps

module tb_bitmap_block_allocator
  import bba_pkg::*;
;

  // Request code 3 is not decoded by the block; it must answer without touching state.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Longest stretch without any word moving on either channel. It covers a free,
  // a stalled response, and drain and register writes between phases, many times
  // over.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Settle time after the last response before the verdict.
  localparam int unsigned TAIL_CYCLES    = 100;
  localparam int unsigned MAX_PRINTS     = 200;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] addr;
  } pool_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] block_addr;
    logic [CNT_W-1:0]  free_count;
  } pool_resp_t;

  // DUT ports, all inputs known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [ADDR_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [REQ_W-1:0]     req_type_i  = '0;
  logic [ADDR_W-1:0]    addr_i      = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STAT_W-1:0]    status_o;
  logic [ADDR_W-1:0]    block_addr_o;
  logic [CNT_W-1:0]     free_count_o;

  bitmap_block_allocator #(
    .MAX_BLOCKS(BBA_MAX_BLOCKS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .addr_i      (addr_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .block_addr_o(block_addr_o),
    .free_count_o(free_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the pool: registers as last written, used bitmap and free count.
  logic [ADDR_W-1:0]         cfg_base   = '0;
  logic [PSIZE_W-1:0]        cfg_psize  = '0;
  logic [BSIZE_W-1:0]        cfg_bsize  = 16'd64;
  logic [CNT_W-1:0]          cfg_bcount = '0;
  logic [BBA_MAX_BLOCKS-1:0] used_bits  = '0;
  logic [CNT_W-1:0]          free_blocks = '0;

  pool_req_t   req_q[$];    // requests waiting to be driven
  pool_resp_t  resp_q[$];   // responses owed by the block, oldest first

  int unsigned sent_total    = 0;
  int unsigned checked_total = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_pct      = 0;   // chance per cycle that a stall burst starts
  int unsigned gen_live      = 0;   // rough count of blocks held, steers free addresses

  // Driver / monitor private state
  logic        tx_hold;
  int unsigned tx_gap = 0;
  pool_req_t   tx_next;
  int unsigned rx_gap = 0;
  int unsigned quiet_cycles = 0;
  pool_resp_t  want;

  // Work out the response to one accepted request and update the shadow pool.
  function automatic pool_resp_t apply_request(input logic [REQ_W-1:0]  kind,
                                               input logic [ADDR_W-1:0] a);
    pool_resp_t       r;
    int unsigned      n;
    int unsigned      idx;
    logic [ADDR_W:0]  pool_limit;
    logic             owned;
    logic             found;
    // blocks beyond the bitmap depth do not exist
    n = (cfg_bcount < BBA_MAX_BLOCKS) ? cfg_bcount : BBA_MAX_BLOCKS;
    r.status     = STAT_OK;
    r.block_addr = '0;
    case (kind)
      REQ_ALLOC: begin
        r.status = STAT_NO_FREE;
        found    = 1'b0;
        // count may claim free blocks while the usable map is full: stays no-free
        if (free_blocks != 0) begin
          for (int i = 0; i < n && !found; i++) begin
            if (!used_bits[i]) begin
              used_bits[i] = 1'b1;
              free_blocks  = free_blocks - 1'b1;
              // wraps at 32 bits; zero block size hands out the base every time
              r.block_addr = cfg_base + 32'(i) * {16'h0, cfg_bsize};
              r.status     = STAT_OK;
              found        = 1'b1;
            end
          end
        end
      end
      REQ_FREE: begin
        // end of pool taken on 33 bits so a high base cannot wrap
        pool_limit = {1'b0, cfg_base} + {9'h0, cfg_psize};
        owned = (cfg_base != 0) && (a != 0) && (a >= cfg_base) &&
                ({1'b0, a} < pool_limit) && (cfg_bsize != 0);
        idx = 0;
        if (owned) begin
          idx = (a - cfg_base) / cfg_bsize;
          if (idx >= n) owned = 1'b0;
        end
        if (!owned) begin
          r.status = STAT_NOT_OWNED;
        end else if (!used_bits[idx]) begin
          r.status = STAT_ALREADY;
        end else begin
          used_bits[idx] = 1'b0;
          if (free_blocks < CNT_MAX) free_blocks = free_blocks + 1'b1;
        end
      end
      REQ_CLEAR: begin
        used_bits   = '0;
        free_blocks = n[CNT_W-1:0];
      end
      default: begin
        // undecoded request: state untouched
      end
    endcase
    r.free_count = free_blocks;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] exp_val);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at response %0d: %s got 0x%0h want 0x%0h",
               checked_total, what, got, exp_val);
    mismatches++;
  endtask

  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] a);
    pool_req_t r;
    r.kind = kind;
    r.addr = a;
    req_q.push_back(r);
    sent_total++;
  endtask

  // Register write at a clock edge; the shadow copy follows at once since
  // writes only happen while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_POOL_BASE:  cfg_base   = data;
      CFG_POOL_SIZE:  cfg_psize  = data[PSIZE_W-1:0];
      CFG_BLOCK_SIZE: cfg_bsize  = data[BSIZE_W-1:0];
      default:        cfg_bcount = data[CNT_W-1:0];
    endcase
  endtask

  task automatic program_pool(input logic [ADDR_W-1:0]  base,
                              input logic [PSIZE_W-1:0] size,
                              input logic [BSIZE_W-1:0] bsize,
                              input logic [CNT_W-1:0]   count);
    write_reg(CFG_POOL_BASE,   base);
    write_reg(CFG_POOL_SIZE,   {8'h0, size});
    write_reg(CFG_BLOCK_SIZE,  {16'h0, bsize});
    write_reg(CFG_BLOCK_COUNT, {23'h0, count});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender holds off until every owed response is back; the block is then idle.
  task automatic drain();
    while (checked_total != sent_total) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Mostly alloc/free traffic that hits real blocks, with some noise on top.
  task automatic queue_random(input int unsigned items);
    int unsigned      roll;
    int unsigned      k;
    logic [ADDR_W-1:0] a;
    for (int j = 0; j < items; j++) begin
      roll = $urandom_range(99);
      a    = $urandom;
      if (roll < 45) begin
        push_req(REQ_ALLOC, a);
        if (gen_live < cfg_bcount) gen_live++;
      end else if (roll < 85) begin
        // favour blocks that are likely held; allocation fills from the bottom
        if (gen_live != 0 && $urandom_range(4) != 0) k = $urandom_range(gen_live - 1, 0);
        else k = $urandom_range(cfg_bcount - 1, 0);
        a = cfg_base + k * cfg_bsize + $urandom_range(cfg_bsize - 1, 0);
        push_req(REQ_FREE, a);
        if (gen_live != 0) gen_live--;
      end else if (roll < 90) begin
        push_req(REQ_FREE, a);
      end else if (roll < 93) begin
        // pool boundaries
        case ($urandom_range(2))
          0:       a = cfg_base - 1;
          1:       a = cfg_base + cfg_psize;
          default: a = cfg_base + cfg_psize - 1;
        endcase
        push_req(REQ_FREE, a);
      end else if (roll < 97) begin
        push_req(REQ_CLEAR, a);
        gen_live = 0;
      end else begin
        push_req(REQ_UNUSED, a);
      end
    end
  endtask

  // Request driver: predicts at acceptance, then presents the next word or idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= '0;
      addr_i     <= '0;
      tx_gap      = 0;
    end else begin
      tx_hold = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        resp_q.push_back(apply_request(req_type_i, addr_i));
        tx_hold = 1'b0;
      end
      if (!tx_hold && req_q.size() != 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if ($urandom_range(99) < idle_pct) begin
          tx_gap = $urandom_range(3, 0);
        end else begin
          tx_next    = req_q.pop_front();
          req_type_i <= tx_next.kind;
          addr_i     <= tx_next.addr;
          tx_hold    = 1'b1;
        end
      end
      in_valid_i <= tx_hold;
    end
  end

  // Response monitor: checks each word against the oldest owed response,
  // stalls at random and runs the watchdog.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap       = 0;
      quiet_cycles = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (resp_q.size() == 0) begin
          report_mismatch("response with none owed, status", ADDR_W'(status_o), '0);
        end else begin
          want = resp_q.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", ADDR_W'(status_o), ADDR_W'(want.status));
          if (block_addr_o !== want.block_addr)
            report_mismatch("block_addr", block_addr_o, want.block_addr);
          if (free_count_o !== want.free_count)
            report_mismatch("free_count", ADDR_W'(free_count_o), ADDR_W'(want.free_count));
        end
        checked_total++;
      end

      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", quiet_cycles);
        $display("tb_bitmap_block_allocator failed");
        $finish;
      end

      if (rx_gap > 0) rx_gap--;
      else if ($urandom_range(99) < idle_pct) rx_gap = $urandom_range(4, 1);
      out_ready_i <= (rx_gap == 0);
    end
  end

  initial begin
    logic [ADDR_W-1:0] base;
    int unsigned       blk_sz;
    int unsigned       blk_n;
    int unsigned       span;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 30;

    // Reset defaults: no blocks, free count zero until a clear.
    push_req(REQ_ALLOC,  32'h0);
    push_req(REQ_FREE,   32'h0);
    push_req(REQ_UNUSED, 32'hFFFF_FFFF);
    push_req(REQ_CLEAR,  32'h0);
    drain();

    // Small regular pool: basic alloc/free and ownership edges.
    program_pool(32'h0000_1000, 24'd1024, 16'd64, 9'd16);
    push_req(REQ_CLEAR, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_FREE,  32'h0000_1040);            // block 1 back
    push_req(REQ_FREE,  32'h0000_1045);            // same block again, now free
    push_req(REQ_FREE,  32'h0000_0FFF);            // just below base
    push_req(REQ_FREE,  32'h0000_1400);            // one past the pool end
    push_req(REQ_FREE,  32'h0000_13FF);            // last byte, block unused
    push_req(REQ_ALLOC, 32'h0);                    // lowest free is block 1 again
    drain();

    // Count claims free blocks but the usable map is full; index past block count.
    program_pool(32'h0000_2000, 24'hFF_FFFF, 16'd1, 9'd256);
    push_req(REQ_CLEAR, 32'h0);
    drain();
    program_pool(32'h0000_2000, 24'hFF_FFFF, 16'd1, 9'd2);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_FREE,  32'h0000_2005);
    drain();

    // Extremes: top base, widest size and block; addresses wrap past 2^32.
    program_pool(32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 9'd256);
    push_req(REQ_CLEAR, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_FREE,  32'hFFFF_FFFF);
    drain();

    // Zero block size: every allocate returns the base, free never owns.
    program_pool(32'h0000_0100, 24'h00_1000, 16'd0, 9'd8);
    push_req(REQ_CLEAR, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_FREE,  32'h0000_0100);
    drain();

    // Zero base and size, block count above the bitmap depth (capped).
    program_pool(32'h0, 24'h0, 16'd64, 9'd300);
    push_req(REQ_CLEAR, 32'h0);
    push_req(REQ_ALLOC, 32'h0);
    push_req(REQ_FREE,  32'h0);
    drain();

    // Random pools. Two phases run without stalls, the last one among them.
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(3))
        0:       blk_sz = 1;
        1:       blk_sz = 1 << $urandom_range(8, 2);
        2:       blk_sz = $urandom_range(65535, 1);
        default: blk_sz = 65535;
      endcase
      if (p == 1)      blk_n = 256;
      else if (p == 2) blk_n = $urandom_range(8, 1);
      else             blk_n = $urandom_range(256, 1);
      base = $urandom;
      if (p == 3) base = 32'hFF00_0000 | $urandom_range(32'h00FF_FFFF, 0);
      if (base == 0) base = 32'h1;
      span = blk_n * blk_sz;                        // fits 24 bits at the largest
      if ($urandom_range(3) == 0) span = $urandom_range(24'hFF_FFFF, 0);
      idle_pct = (p == 2 || p == 5) ? 0 : $urandom_range(50, 10);
      program_pool(base, span[PSIZE_W-1:0], blk_sz[BSIZE_W-1:0], blk_n[CNT_W-1:0]);
      // software normally clears after configuring; now and then it does not
      if ($urandom_range(9) != 0) begin
        push_req(REQ_CLEAR, $urandom);
        gen_live = 0;
      end
      queue_random(70);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (resp_q.size() != 0)
      report_mismatch("responses never delivered, count", ADDR_W'(resp_q.size()), '0);
    if (mismatches == 0) begin
      $display("tb_bitmap_block_allocator passed");
    end else begin
      $display("tb_bitmap_block_allocator failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bba_pkg.sv
src/bba_map_mem.sv
src/bba_div.sv
src/bitmap_block_allocator.sv
verif/tb_bitmap_block_allocator.sv
